>>> src/point_rotate_translate_project_unit_defines.svh
// assertion macros for the point transform top module
`ifndef POINT_ROTATE_TRANSLATE_PROJECT_UNIT_DEFINES_SVH
`define POINT_ROTATE_TRANSLATE_PROJECT_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PRTP_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define PRTP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`endif

>>> src/prtp_pkg.sv
// shared types, widths and register codes for the point transform unit
`default_nettype none

package prtp_pkg;

	// parameter defaults
	localparam int unsigned SIN_ENTRIES_DEF = 1024;
	localparam int unsigned SCREEN_W_DEF    = 320;
	localparam int unsigned SCREEN_H_DEF    = 200;
	localparam int unsigned SPRITE_SIZE_DEF = 16;

	// datapath widths
	localparam int DATA_W  = 16;
	localparam int COORD_W = 20;
	localparam int SIN_W   = 16;
	localparam int PROD_W  = COORD_W + SIN_W;
	localparam int FRAC    = 14;
	localparam int VIEW_W  = 21;
	localparam int FOCAL_W = 12;
	localparam int NUM_W   = 32;
	localparam int DEN_W   = VIEW_W;
	localparam int WORK_W  = NUM_W + DEN_W + 1;
	localparam int QF_W    = NUM_W + 2;
	localparam int EXT_W   = QF_W + 1;
	localparam int FIFO_DEPTH = 32;

	// configuration register codes
	localparam int IDX_W = 4;
	localparam logic [IDX_W-1:0] REG_MODEL_OFFSET_Z = 4'd0;
	localparam logic [IDX_W-1:0] REG_ANGLE_X        = 4'd1;
	localparam logic [IDX_W-1:0] REG_ANGLE_Y        = 4'd2;
	localparam logic [IDX_W-1:0] REG_ANGLE_Z        = 4'd3;
	localparam logic [IDX_W-1:0] REG_VIEW_OFFSET_X  = 4'd4;
	localparam logic [IDX_W-1:0] REG_VIEW_OFFSET_Y  = 4'd5;
	localparam logic [IDX_W-1:0] REG_VIEW_OFFSET_Z  = 4'd6;
	localparam logic [IDX_W-1:0] REG_FOCAL_DISTANCE = 4'd7;

	localparam logic [FOCAL_W-1:0] FOCAL_RESET = 12'd300;

	typedef struct packed {
		logic signed [DATA_W-1:0] point_x;
		logic signed [DATA_W-1:0] point_y;
		logic signed [DATA_W-1:0] point_z;
	} prtp_point_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] screen_x;
		logic signed [DATA_W-1:0] screen_y;
		logic signed [DATA_W-1:0] view_depth;
		logic                     in_front;
		logic                     sprite_fits;
	} prtp_result_t;

	// status that rides along the divider
	typedef struct packed {
		logic                     front;
		logic signed [DATA_W-1:0] depth;
		logic                     neg_x;
		logic                     neg_y;
	} prtp_side_t;

endpackage

`default_nettype wire

>>> src/prtp_sin_rom.sv
// sine and cosine table for one angle register, registered read
`default_nettype none

module prtp_sin_rom #(
	parameter int unsigned SIN_ENTRIES = prtp_pkg::SIN_ENTRIES_DEF
) (
	input  wire logic                                clk,
	input  wire logic        [15:0]                  angle,
	output logic signed [prtp_pkg::SIN_W-1:0]        sin_v,
	output logic signed [prtp_pkg::SIN_W-1:0]        cos_v
);

	localparam int AW    = (SIN_ENTRIES > 1) ? $clog2(SIN_ENTRIES) : 1;
	localparam int LUT_W = $clog2(SIN_ENTRIES + 1);
	localparam int PW    = 16 + LUT_W;
	localparam int EW    = 2 * prtp_pkg::SIN_W;

	typedef logic [EW-1:0] rom_t [SIN_ENTRIES];

	// q1.14 sine of a 16 bit phase, series evaluated in q30
	function automatic logic signed [prtp_pkg::SIN_W-1:0] sine_q14(input logic [15:0] p);
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned s;
		longint unsigned v;
		longint unsigned one;
		one = 64'd1 << 30;
		r = 64'(p[13:0]);
		if (p[14]) begin
			r = 64'd16384 - r;
		end
		x  = (r * 64'd1686629713) >> 14;
		x2 = (x * x) >> 30;
		s  = one;
		s  = one - ((x2 * s) >> 30) / 64'd110;
		s  = one - ((x2 * s) >> 30) / 64'd72;
		s  = one - ((x2 * s) >> 30) / 64'd42;
		s  = one - ((x2 * s) >> 30) / 64'd20;
		s  = one - ((x2 * s) >> 30) / 64'd6;
		v  = (((x * s) >> 30) + 64'd32768) >> 16;
		return p[15] ? -prtp_pkg::SIN_W'(v) : prtp_pkg::SIN_W'(v);
	endfunction

	// entry i holds {sin, cos} of phase i * 65536 / SIN_ENTRIES
	function automatic rom_t build_rom();
		rom_t             t;
		longint unsigned  ph;
		logic [15:0]      p;
		for (int i = 0; i < SIN_ENTRIES; i++) begin
			ph = (64'(i) << 16) / SIN_ENTRIES;
			p = ph[15:0];
			t[i] = {sine_q14(p), sine_q14(p + 16'd16384)};
		end
		return t;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [PW-1:0] scaled;
	logic [AW-1:0] idx;
	logic [EW-1:0] data_q;

	// index is the top bits of angle * SIN_ENTRIES
	assign scaled = PW'(angle) * PW'(SIN_ENTRIES);
	assign idx    = scaled[16 +: AW];

	// registered table read
	always_ff @(posedge clk) begin
		data_q <= ROM[idx];
	end

	assign sin_v = data_q[EW-1 -: prtp_pkg::SIN_W];
	assign cos_v = data_q[prtp_pkg::SIN_W-1:0];

endmodule

`default_nettype wire

>>> src/prtp_rotate.sv
// one planar rotation: multiply stage, then sum and round stage
`default_nettype none

module prtp_rotate (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  vld,
	input  wire logic signed [prtp_pkg::COORD_W-1:0]   u,
	input  wire logic signed [prtp_pkg::COORD_W-1:0]   v,
	input  wire logic signed [prtp_pkg::COORD_W-1:0]   w,
	input  wire logic signed [prtp_pkg::SIN_W-1:0]     cos_v,
	input  wire logic signed [prtp_pkg::SIN_W-1:0]     sin_v,
	output logic                                       rvld,
	output logic signed [prtp_pkg::COORD_W-1:0]        ru,
	output logic signed [prtp_pkg::COORD_W-1:0]        rv,
	output logic signed [prtp_pkg::COORD_W-1:0]        rw
);

	localparam int PW = prtp_pkg::PROD_W;
	localparam int SW = prtp_pkg::PROD_W + 1;
	localparam logic signed [SW-1:0] ROUND = SW'(1 << (prtp_pkg::FRAC - 1));

	logic                                vld_s1, vld_s2;
	logic signed [PW-1:0]                uc_s1, vs_s1, us_s1, vc_s1;
	logic signed [prtp_pkg::COORD_W-1:0] w_s1;
	logic signed [prtp_pkg::COORD_W-1:0] u_s2, v_s2, w_s2;
	logic signed [SW-1:0]                sum_u, sum_v;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	// four products
	always_ff @(posedge clk) begin
		uc_s1 <= PW'(u) * PW'(cos_v);
		vs_s1 <= PW'(v) * PW'(sin_v);
		us_s1 <= PW'(u) * PW'(sin_v);
		vc_s1 <= PW'(v) * PW'(cos_v);
		w_s1  <= w;
	end

	// sums rounded to nearest, ties up
	assign sum_u = SW'(uc_s1) - SW'(vs_s1) + ROUND;
	assign sum_v = SW'(us_s1) + SW'(vc_s1) + ROUND;

	always_ff @(posedge clk) begin
		u_s2 <= sum_u[prtp_pkg::FRAC +: prtp_pkg::COORD_W];
		v_s2 <= sum_v[prtp_pkg::FRAC +: prtp_pkg::COORD_W];
		w_s2 <= w_s1;
	end

	assign rvld = vld_s2;
	assign ru   = u_s2;
	assign rv   = v_s2;
	assign rw   = w_s2;

endmodule

`default_nettype wire

>>> src/prtp_div.sv
// two-lane pipelined restoring divider, two quotient bits per stage
`default_nettype none

module prtp_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               vld,
	input  wire logic [prtp_pkg::NUM_W-1:0]         num_x,
	input  wire logic [prtp_pkg::NUM_W-1:0]         num_y,
	input  wire logic [prtp_pkg::DEN_W-1:0]         den,
	input  wire prtp_pkg::prtp_side_t               side,
	output logic                                    rvld,
	output logic [prtp_pkg::NUM_W-1:0]              qx,
	output logic [prtp_pkg::NUM_W-1:0]              qy,
	output logic                                    rx_nz,
	output logic                                    ry_nz,
	output prtp_pkg::prtp_side_t                    rside
);

	localparam int NW     = prtp_pkg::NUM_W;
	localparam int DW     = prtp_pkg::DEN_W;
	localparam int WW     = prtp_pkg::WORK_W;
	localparam int STAGES = NW / 2;

	// one shift-compare-subtract step on {remainder, numerator}
	function automatic logic [WW-1:0] div_step(input logic [WW-1:0] wk,
		input logic [DW-1:0] d);
		logic [WW-1:0] t;
		t = wk << 1;
		if (t[WW-1:NW] >= (DW+1)'(d)) begin
			t[WW-1:NW] = t[WW-1:NW] - (DW+1)'(d);
			t[0] = 1'b1;
		end
		return t;
	endfunction

	logic                 vld_s  [STAGES];
	logic [WW-1:0]        wx_s   [STAGES];
	logic [WW-1:0]        wy_s   [STAGES];
	logic [DW-1:0]        den_s  [STAGES];
	prtp_pkg::prtp_side_t side_s [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [WW-1:0]        wx_in, wy_in;
		logic [DW-1:0]        den_in;
		prtp_pkg::prtp_side_t side_in;
		logic                 vld_in;

		if (g == 0) begin : g_first
			assign wx_in   = WW'(num_x);
			assign wy_in   = WW'(num_y);
			assign den_in  = den;
			assign side_in = side;
			assign vld_in  = vld;
		end else begin : g_next
			assign wx_in   = wx_s[g-1];
			assign wy_in   = wy_s[g-1];
			assign den_in  = den_s[g-1];
			assign side_in = side_s[g-1];
			assign vld_in  = vld_s[g-1];
		end

		// stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_in;
			end
		end

		// two steps per lane
		always_ff @(posedge clk) begin
			wx_s[g]   <= div_step(div_step(wx_in, den_in), den_in);
			wy_s[g]   <= div_step(div_step(wy_in, den_in), den_in);
			den_s[g]  <= den_in;
			side_s[g] <= side_in;
		end
	end

	assign rvld  = vld_s[STAGES-1];
	assign qx    = wx_s[STAGES-1][NW-1:0];
	assign qy    = wy_s[STAGES-1][NW-1:0];
	assign rx_nz = |wx_s[STAGES-1][WW-1:NW];
	assign ry_nz = |wy_s[STAGES-1][WW-1:NW];
	assign rside = side_s[STAGES-1];

endmodule

`default_nettype wire

>>> src/point_rotate_translate_project_unit.sv
// Point rotate, translate and perspective projection unit.
// Path from point beat to result_valid: input stage, three rotations, view
// offset, multiply and magnitude stages, divider, correction, result queue.
// Throughput: one point per cycle; a credit count over the 32-entry result
// queue and output register drops point_ready once 32 results are unclaimed.
// Reset: arst_n clears all valid bits and counters; config registers reset to zero, focal distance to 300.
`default_nettype none

module point_rotate_translate_project_unit #(
	parameter int unsigned SIN_ENTRIES = prtp_pkg::SIN_ENTRIES_DEF,
	parameter int unsigned SCREEN_W    = prtp_pkg::SCREEN_W_DEF,
	parameter int unsigned SCREEN_H    = prtp_pkg::SCREEN_H_DEF,
	parameter int unsigned SPRITE_SIZE = prtp_pkg::SPRITE_SIZE_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              point_valid,
	output logic                                   point_ready,
	input  wire prtp_pkg::prtp_point_t             point_data,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output prtp_pkg::prtp_result_t                 result_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [prtp_pkg::IDX_W-1:0]        cfg_index,
	input  wire logic [prtp_pkg::DATA_W-1:0]       cfg_data
);

`include "point_rotate_translate_project_unit_defines.svh"

	localparam int CW = prtp_pkg::COORD_W;
	localparam int VW = prtp_pkg::VIEW_W;
	localparam int QW = prtp_pkg::QF_W;
	localparam int XW = prtp_pkg::EXT_W;
	localparam int NW = prtp_pkg::NUM_W;
	localparam int DW = prtp_pkg::DEN_W;
	localparam int FD = prtp_pkg::FIFO_DEPTH;
	localparam int AW = $clog2(FD);
	localparam int PTR_W = AW + 1;
	localparam int CNT_W = AW + 1;

	localparam logic signed [XW-1:0] KX    = XW'(SCREEN_W / 2);
	localparam logic signed [XW-1:0] KY    = XW'(SCREEN_H / 2);
	localparam logic signed [XW-1:0] KPX   = XW'(SCREEN_W / 2 - SPRITE_SIZE / 2);
	localparam logic signed [XW-1:0] KPY   = XW'(SCREEN_H / 2 - SPRITE_SIZE / 2);
	localparam logic signed [XW-1:0] PXMAX = XW'(SCREEN_W - SPRITE_SIZE);
	localparam logic signed [XW-1:0] PYMAX = XW'(SCREEN_H - SPRITE_SIZE);

	// trunc(q + k + f) from floor quotient q and nonzero fraction flag
	function automatic logic signed [XW-1:0] trunc_add(input logic signed [QW-1:0] q,
		input logic nz, input logic signed [XW-1:0] k);
		logic signed [XW-1:0] base;
		base = XW'(q) + k;
		return (nz && base[XW-1]) ? base + XW'(1) : base;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [XW-1:0] v);
		if (v > XW'(32767)) begin
			return 16'sd32767;
		end else if (v < -XW'(32768)) begin
			return -16'sd32768;
		end else begin
			return v[15:0];
		end
	endfunction

	// configuration registers
	logic signed [15:0]                 moz_q, vox_q, voy_q, voz_q;
	logic        [15:0]                 ang_x_q, ang_y_q, ang_z_q;
	logic        [prtp_pkg::FOCAL_W-1:0] focal_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moz_q   <= '0;
			ang_x_q <= '0;
			ang_y_q <= '0;
			ang_z_q <= '0;
			vox_q   <= '0;
			voy_q   <= '0;
			voz_q   <= '0;
			focal_q <= prtp_pkg::FOCAL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				prtp_pkg::REG_MODEL_OFFSET_Z: moz_q   <= cfg_data;
				prtp_pkg::REG_ANGLE_X:        ang_x_q <= cfg_data;
				prtp_pkg::REG_ANGLE_Y:        ang_y_q <= cfg_data;
				prtp_pkg::REG_ANGLE_Z:        ang_z_q <= cfg_data;
				prtp_pkg::REG_VIEW_OFFSET_X:  vox_q   <= cfg_data;
				prtp_pkg::REG_VIEW_OFFSET_Y:  voy_q   <= cfg_data;
				prtp_pkg::REG_VIEW_OFFSET_Z:  voz_q   <= cfg_data;
				prtp_pkg::REG_FOCAL_DISTANCE: focal_q <= cfg_data[prtp_pkg::FOCAL_W-1:0];
				default: ;
			endcase
		end
	end

	// sine and cosine tables
	logic signed [prtp_pkg::SIN_W-1:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;

	prtp_sin_rom #(.SIN_ENTRIES(SIN_ENTRIES)) u_rom_x (
		.clk(clk), .angle(ang_x_q), .sin_v(sin_x), .cos_v(cos_x));
	prtp_sin_rom #(.SIN_ENTRIES(SIN_ENTRIES)) u_rom_y (
		.clk(clk), .angle(ang_y_q), .sin_v(sin_y), .cos_v(cos_y));
	prtp_sin_rom #(.SIN_ENTRIES(SIN_ENTRIES)) u_rom_z (
		.clk(clk), .angle(ang_z_q), .sin_v(sin_z), .cos_v(cos_z));

	// credit count and point acceptance
	logic             acc_in, acc_out;
	logic [CNT_W-1:0] cnt_q;

	assign point_ready = (cnt_q != CNT_W'(FD));
	assign acc_in      = point_valid && point_ready;
	assign acc_out     = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(acc_in) - CNT_W'(acc_out);
		end
	end

	// input stage with model z offset
	logic                 vld_s1;
	logic signed [CW-1:0] x_s1, y_s1, z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc_in;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= CW'(point_data.point_x);
		y_s1 <= CW'(point_data.point_y);
		z_s1 <= CW'(point_data.point_z) + CW'(moz_q);
	end

	// rotations about x, y, z
	logic                 r1_vld, r2_vld, r3_vld;
	logic signed [CW-1:0] r1_u, r1_v, r1_w, r2_u, r2_v, r2_w, r3_u, r3_v, r3_w;

	prtp_rotate u_rot_x (
		.clk(clk), .arst_n(arst_n), .vld(vld_s1),
		.u(y_s1), .v(z_s1), .w(x_s1), .cos_v(cos_x), .sin_v(sin_x),
		.rvld(r1_vld), .ru(r1_u), .rv(r1_v), .rw(r1_w));

	prtp_rotate u_rot_y (
		.clk(clk), .arst_n(arst_n), .vld(r1_vld),
		.u(r1_w), .v(r1_v), .w(r1_u), .cos_v(cos_y), .sin_v(sin_y),
		.rvld(r2_vld), .ru(r2_u), .rv(r2_v), .rw(r2_w));

	prtp_rotate u_rot_z (
		.clk(clk), .arst_n(arst_n), .vld(r2_vld),
		.u(r2_u), .v(r2_w), .w(r2_v), .cos_v(cos_z), .sin_v(sin_z),
		.rvld(r3_vld), .ru(r3_u), .rv(r3_v), .rw(r3_w));

	// view offset
	logic                 vld_s8;
	logic signed [VW-1:0] x_s8, y_s8, z_s8;

	always_ff @(posedge clk) begin
		x_s8 <= VW'(r3_u) + VW'(vox_q);
		y_s8 <= VW'(r3_v) + VW'(voy_q);
		z_s8 <= VW'(r3_w) + VW'(voz_q);
	end

	// projection numerators, depth flags
	logic                 vld_s9;
	logic signed [QW-1:0] nx_s9, ny_s9;
	logic signed [VW-1:0] z_s9;
	logic                 front_s9;
	logic signed [15:0]   depth_s9;

	always_ff @(posedge clk) begin
		nx_s9    <= QW'(x_s8) * QW'($signed({1'b0, focal_q}));
		ny_s9    <= QW'(y_s8) * QW'($signed({1'b0, focal_q}));
		z_s9     <= z_s8;
		front_s9 <= z_s8[VW-1];
		depth_s9 <= sat16(XW'(z_s8));
	end

	// magnitudes for the divider
	logic                 vld_s10;
	logic signed [QW-1:0] ax, ay;
	logic signed [VW-1:0] az;
	logic [NW-1:0]        num_x_s10, num_y_s10;
	logic [DW-1:0]        den_s10;
	prtp_pkg::prtp_side_t side_s10;

	assign ax = nx_s9[QW-1] ? -nx_s9 : nx_s9;
	assign ay = ny_s9[QW-1] ? -ny_s9 : ny_s9;
	assign az = -z_s9;

	always_ff @(posedge clk) begin
		num_x_s10        <= ax[NW-1:0];
		num_y_s10        <= ay[NW-1:0];
		den_s10          <= az[DW-1:0];
		side_s10.front   <= front_s9;
		side_s10.depth   <= depth_s9;
		side_s10.neg_x   <= !nx_s9[QW-1] && (nx_s9 != '0);
		side_s10.neg_y   <= !ny_s9[QW-1] && (ny_s9 != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s8  <= r3_vld;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	// divide by depth magnitude
	logic                 d_vld, d_rx_nz, d_ry_nz;
	logic [NW-1:0]        d_qx, d_qy;
	prtp_pkg::prtp_side_t d_side;

	prtp_div u_div (
		.clk(clk), .arst_n(arst_n), .vld(vld_s10),
		.num_x(num_x_s10), .num_y(num_y_s10), .den(den_s10), .side(side_s10),
		.rvld(d_vld), .qx(d_qx), .qy(d_qy), .rx_nz(d_rx_nz), .ry_nz(d_ry_nz),
		.rside(d_side));

	// floor quotient of numerator over depth
	logic                 vld_s27;
	logic signed [QW-1:0] qx_s27, qy_s27;
	logic                 rx_s27, ry_s27;
	prtp_pkg::prtp_side_t side_s27;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s27 <= 1'b0;
		end else begin
			vld_s27 <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		qx_s27   <= d_side.neg_x ? -QW'(d_qx) - QW'(d_rx_nz) : QW'(d_qx);
		qy_s27   <= d_side.neg_y ? -QW'(d_qy) - QW'(d_ry_nz) : QW'(d_qy);
		rx_s27   <= d_rx_nz;
		ry_s27   <= d_ry_nz;
		side_s27 <= d_side;
	end

	// screen position, sprite window, result assembly
	logic signed [XW-1:0]   sx, sy, px, py;
	logic                   fits;
	prtp_pkg::prtp_result_t res;

	assign sx   = trunc_add(qx_s27, rx_s27, KX);
	assign sy   = trunc_add(qy_s27, ry_s27, KY);
	assign px   = trunc_add(qx_s27, rx_s27, KPX);
	assign py   = trunc_add(qy_s27, ry_s27, KPY);
	assign fits = (px > XW'(0)) && (px < PXMAX) && (py > XW'(0)) && (py < PYMAX);

	always_comb begin
		res.screen_x    = side_s27.front ? sat16(sx) : '0;
		res.screen_y    = side_s27.front ? sat16(sy) : '0;
		res.view_depth  = side_s27.depth;
		res.in_front    = side_s27.front;
		res.sprite_fits = side_s27.front && fits;
	end

	// result queue, head read registered into the output beat
	prtp_pkg::prtp_result_t fifo_q [FD];
	prtp_pkg::prtp_result_t out_q;
	logic [PTR_W-1:0]       wptr_q, rptr_q;
	logic                   out_vld_q;
	logic                   load;

	assign load = (wptr_q != rptr_q) && (!out_vld_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q    <= '0;
			rptr_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (vld_s27) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (load) begin
				rptr_q    <= rptr_q + PTR_W'(1);
				out_vld_q <= 1'b1;
			end else if (acc_out) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s27) begin
			fifo_q[wptr_q[AW-1:0]] <= res;
		end
		if (load) begin
			out_q <= fifo_q[rptr_q[AW-1:0]];
		end
	end

	assign result_valid = out_vld_q;
	assign result_data  = out_q;

	// checks
	`PRTP_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(FD))
	`PRTP_ASSERT_IMPLY(a_result_has_credit, result_valid, cnt_q != '0)
	`PRTP_ASSERT_IMPLY(a_queue_room, vld_s27, (wptr_q - rptr_q) != PTR_W'(FD))
	`PRTP_ASSERT_NEXT(a_accept_counts, acc_in && !acc_out, cnt_q != '0)

endmodule

`default_nettype wire
